@@ rtl/pba_pkg.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// pba_pkg
// types and constants shared by the page bitmap allocator
// ---------------------------------------------------------------------------
package pba_pkg;
	localparam int NUM_PAGES  = 65536;
	localparam int PAGE_W     = $clog2(NUM_PAGES);
	localparam int CNT_W      = PAGE_W + 1;
	localparam int WORD_W     = 64;
	localparam int WIDX_W     = $clog2(WORD_W);
	localparam int NUM_WORDS  = NUM_PAGES / WORD_W;
	localparam int ADDR_W     = $clog2(NUM_WORDS);
	localparam int QDEPTH     = 2;

	localparam logic [1:0] OP_ALLOC = 2'd0;
	localparam logic [1:0] OP_FREE  = 2'd1;
	localparam logic [1:0] OP_MARK  = 2'd2;
	localparam logic [1:0] OP_QUERY = 2'd3;

	typedef struct packed {
		logic [1:0]  op;
		logic [15:0] page;
		logic [16:0] count;
		logic        value;
	} in_t;

	typedef struct packed {
		logic        ok;
		logic [15:0] start_page;
		logic        page_used;
		logic [16:0] pages_allocated;
	} out_t;

	typedef struct packed {
		logic [1:0]        op;
		logic [PAGE_W-1:0] page;
		logic [CNT_W-1:0]  count;
		logic              value;
		logic              page_ok;
		logic              cnt_ok;
	} cmd_t;
endpackage
`default_nettype wire

@@ rtl/pba_ram.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// pba_ram
// generic single port ram with registered read
// ---------------------------------------------------------------------------
module pba_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] addr,
	input  wire logic [WIDTH-1:0]         wdata,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end
endmodule
`default_nettype wire

@@ rtl/pba_front.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// pba_front
// accepts items, range-checks them and queues commands for the engine
// ---------------------------------------------------------------------------
module pba_front (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push,
	output logic               full,
	input  wire pba_pkg::in_t  in_data,
	output logic               cmd_valid,
	input  wire logic          cmd_take,
	output pba_pkg::cmd_t      cmd
);
	localparam int PW = $clog2(pba_pkg::QDEPTH);
	pba_pkg::cmd_t    q_q [pba_pkg::QDEPTH];
	logic [PW-1:0]    wp_q, rp_q;
	logic [PW:0]      cnt_q;
	pba_pkg::cmd_t    c;
	logic             do_push, do_pop;

	always_comb begin
		c.op      = in_data.op;
		c.page    = pba_pkg::PAGE_W'(in_data.page);
		c.count   = pba_pkg::CNT_W'(in_data.count);
		c.value   = in_data.value;
		c.page_ok = {1'b0, in_data.page} < 17'(pba_pkg::NUM_PAGES);
		c.cnt_ok  = in_data.count != '0 && {1'b0, in_data.count} <= 18'(pba_pkg::NUM_PAGES);
	end

	assign full      = cnt_q == (PW+1)'(pba_pkg::QDEPTH);
	assign cmd_valid = cnt_q != '0;
	assign cmd       = q_q[rp_q];
	assign do_push   = push && !full;
	assign do_pop    = cmd_take && cmd_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			q_q[wp_q] <= c;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) wp_q <= wp_q + 1'b1;
			if (do_pop)  rp_q <= rp_q + 1'b1;
			cnt_q <= cnt_q + (PW+1)'(do_push) - (PW+1)'(do_pop);
		end
	end
endmodule
`default_nettype wire

@@ rtl/pba_engine.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// pba_engine
// carries out commands on the bitmap ram, a whole bitmap word or a single page per step
// ---------------------------------------------------------------------------
module pba_engine (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           cmd_valid,
	output logic                cmd_take,
	input  wire pba_pkg::cmd_t  cmd,
	output logic                empty,
	input  wire logic           pop,
	output pba_pkg::out_t       out_data
);
	localparam int AW = pba_pkg::ADDR_W;
	localparam int WW = pba_pkg::WORD_W;
	localparam int IW = pba_pkg::WIDX_W;
	localparam int CW = pba_pkg::CNT_W;

	localparam logic [3:0] ST_CLR   = 4'd0;
	localparam logic [3:0] ST_IDLE  = 4'd1;
	localparam logic [3:0] ST_ARD   = 4'd2;
	localparam logic [3:0] ST_ASCAN = 4'd3;
	localparam logic [3:0] ST_SRD   = 4'd4;
	localparam logic [3:0] ST_SMOD  = 4'd5;
	localparam logic [3:0] ST_HRD   = 4'd6;
	localparam logic [3:0] ST_HSCAN = 4'd7;
	localparam logic [3:0] ST_BINIT = 4'd8;
	localparam logic [3:0] ST_BRD   = 4'd9;
	localparam logic [3:0] ST_BSCAN = 4'd10;
	localparam logic [3:0] ST_QRD   = 4'd11;
	localparam logic [3:0] ST_QBIT  = 4'd12;
	localparam logic [3:0] ST_DONE  = 4'd13;

	localparam logic [CW-1:0] NP   = CW'(pba_pkg::NUM_PAGES);
	localparam logic [CW-1:0] STEP = CW'(WW);
	localparam logic [CW-1:0] ONE  = CW'(1);

	logic [3:0]    st_q;
	logic [AW-1:0] addr, clr_q;
	logic [WW-1:0] wdata, rdata, mask;
	logic          we;
	logic [CW-1:0] hint_q, acnt_q, pos_q, run_q, e_q;
	logic [CW-1:0] nxt_page, nxt_word, free_cnt;
	logic [CW:0]   free_sum, free_lim;
	logic [IW-1:0] bit_idx, hi_idx;
	logic          bit_val, last_word, alloc_bad;
	pba_pkg::cmd_t c_q;
	pba_pkg::out_t res_q, res_init;
	logic          full_q;

	pba_ram #(.WIDTH(WW), .DEPTH(pba_pkg::NUM_WORDS)) u_ram (
		.clk(clk), .we(we), .addr(addr), .wdata(wdata), .rdata(rdata)
	);

	always_comb begin
		bit_idx   = pos_q[IW-1:0];
		bit_val   = rdata[bit_idx];
		last_word = pos_q[CW-1:IW] == e_q[CW-1:IW];
		hi_idx    = last_word ? e_q[IW-1:0] : '1;
		mask      = ({WW{1'b1}} << bit_idx) & ({WW{1'b1}} >> (IW'(WW-1) - hi_idx));
		nxt_page  = pos_q + ONE;
		nxt_word  = (pos_q | CW'(WW-1)) + ONE;
		free_sum  = (CW+1)'(cmd.page) + (CW+1)'(cmd.count);
		free_lim  = (free_sum > (CW+1)'(NP)) ? (CW+1)'(NP) : free_sum;
		free_cnt  = CW'(free_lim - (CW+1)'(cmd.page));
		alloc_bad = !cmd.cnt_ok || hint_q >= NP;
		res_init  = '0;
		res_init.ok        = !(cmd.op == pba_pkg::OP_ALLOC && alloc_bad);
		res_init.page_used = cmd.op == pba_pkg::OP_QUERY && !cmd.page_ok;
		we    = 1'b0;
		wdata = rdata;
		addr  = pos_q[IW +: AW];
		case (st_q)
			ST_CLR: begin
				we    = 1'b1;
				wdata = '1;
				addr  = clr_q;
			end
			ST_SMOD: begin
				we    = 1'b1;
				wdata = (c_q.op == pba_pkg::OP_ALLOC) ? (rdata | mask) : (rdata & ~mask);
			end
			ST_QBIT: begin
				we             = c_q.op == pba_pkg::OP_MARK;
				wdata[bit_idx] = c_q.value;
			end
			default: ;
		endcase
	end

	assign empty    = !full_q;
	assign out_data = res_q;
	assign cmd_take = st_q == ST_IDLE && !full_q;

	always_ff @(posedge clk) begin
		if (cmd_take && cmd_valid) c_q <= cmd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= ST_CLR;
			clr_q  <= '0;
			hint_q <= '0;
			acnt_q <= '0;
			full_q <= 1'b0;
			pos_q  <= '0;
			run_q  <= '0;
			e_q    <= '0;
			res_q  <= '0;
		end else begin
			if (st_q == ST_DONE) full_q <= 1'b1;
			else if (pop && full_q) full_q <= 1'b0;
			case (st_q)
				ST_CLR: begin
					clr_q <= clr_q + AW'(1);
					if (&clr_q) st_q <= ST_IDLE;
				end
				ST_IDLE: begin
					if (cmd_take && cmd_valid) begin
						res_q <= res_init;
						run_q <= '0;
						case (cmd.op)
							pba_pkg::OP_ALLOC: begin
								if (alloc_bad) st_q <= ST_DONE;
								else begin
									pos_q <= hint_q;
									st_q  <= ST_ARD;
								end
							end
							pba_pkg::OP_FREE: begin
								if (!cmd.page_ok) st_q <= ST_DONE;
								else begin
									acnt_q <= (free_cnt >= acnt_q) ? '0 : acnt_q - free_cnt;
									pos_q  <= CW'(cmd.page);
									e_q    <= CW'(free_lim) - ONE;
									st_q   <= (cmd.count == '0) ? ST_BINIT : ST_SRD;
								end
							end
							default: begin
								if (!cmd.page_ok) st_q <= ST_DONE;
								else begin
									pos_q <= CW'(cmd.page);
									st_q  <= ST_QRD;
								end
							end
						endcase
					end
				end
				// first-fit scan, whole words skipped where possible
				ST_ARD: st_q <= ST_ASCAN;
				ST_ASCAN: begin
					if (bit_idx == '0 && rdata == '1) begin
						run_q <= '0;
						if (nxt_word >= NP) begin
							res_q.ok <= 1'b0;
							st_q     <= ST_DONE;
						end else begin
							pos_q <= nxt_word;
							st_q  <= ST_ARD;
						end
					end else if (bit_idx == '0 && rdata == '0 && run_q + STEP < c_q.count) begin
						run_q <= run_q + STEP;
						if (nxt_word >= NP) begin
							res_q.ok <= 1'b0;
							st_q     <= ST_DONE;
						end else begin
							pos_q <= nxt_word;
							st_q  <= ST_ARD;
						end
					end else if (!bit_val && run_q + ONE == c_q.count) begin
						res_q.start_page <= 16'(nxt_page - c_q.count);
						pos_q  <= nxt_page - c_q.count;
						e_q    <= pos_q;
						acnt_q <= (c_q.count >= NP - acnt_q) ? NP : acnt_q + c_q.count;
						st_q   <= ST_SRD;
					end else begin
						run_q <= bit_val ? '0 : run_q + ONE;
						if (nxt_page >= NP) begin
							res_q.ok <= 1'b0;
							st_q     <= ST_DONE;
						end else begin
							pos_q <= nxt_page;
							if (&bit_idx) st_q <= ST_ARD;
						end
					end
				end
				// set or clear the run, one word per read and write
				ST_SRD: st_q <= ST_SMOD;
				ST_SMOD: begin
					if (last_word) begin
						if (c_q.op == pba_pkg::OP_ALLOC) begin
							if (e_q + ONE >= NP) begin
								hint_q <= NP;
								st_q   <= ST_DONE;
							end else begin
								pos_q <= e_q + ONE;
								st_q  <= ST_HRD;
							end
						end else st_q <= ST_BINIT;
					end else begin
						pos_q <= nxt_word;
						st_q  <= ST_SRD;
					end
				end
				// hint walk forward to the next free page
				ST_HRD: st_q <= ST_HSCAN;
				ST_HSCAN: begin
					if (bit_idx == '0 && rdata == '1) begin
						if (nxt_word >= NP) begin
							hint_q <= NP;
							st_q   <= ST_DONE;
						end else begin
							pos_q <= nxt_word;
							st_q  <= ST_HRD;
						end
					end else if (!bit_val) begin
						hint_q <= pos_q;
						st_q   <= ST_DONE;
					end else if (nxt_page >= NP) begin
						hint_q <= NP;
						st_q   <= ST_DONE;
					end else begin
						pos_q <= nxt_page;
						if (&bit_idx) st_q <= ST_HRD;
					end
				end
				// hint walk down through the free pages below the freed run
				ST_BINIT: begin
					hint_q <= CW'(c_q.page);
					if (c_q.page == '0) st_q <= ST_DONE;
					else begin
						pos_q <= CW'(c_q.page) - ONE;
						st_q  <= ST_BRD;
					end
				end
				ST_BRD: st_q <= ST_BSCAN;
				ST_BSCAN: begin
					if (&bit_idx && rdata == '0) begin
						hint_q <= pos_q - CW'(WW-1);
						if (pos_q[CW-1:IW] == '0) st_q <= ST_DONE;
						else begin
							pos_q <= pos_q - STEP;
							st_q  <= ST_BRD;
						end
					end else if (bit_val) begin
						st_q <= ST_DONE;
					end else begin
						hint_q <= pos_q;
						if (pos_q == '0) st_q <= ST_DONE;
						else begin
							pos_q <= pos_q - ONE;
							if (bit_idx == '0) st_q <= ST_BRD;
						end
					end
				end
				// mark and query
				ST_QRD: st_q <= ST_QBIT;
				ST_QBIT: begin
					if (c_q.op == pba_pkg::OP_QUERY) res_q.page_used <= bit_val;
					st_q <= ST_DONE;
				end
				ST_DONE: begin
					res_q.pages_allocated <= acnt_q;
					st_q <= ST_IDLE;
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

@@ rtl/page_bitmap_allocator_top.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// page_bitmap_allocator_top
// first-fit page allocator over a bitmap ram, one used bit per page
// mark and query: a read state, a bit state and a done state per transaction
// allocate and free: whole 64-page words are skipped or rewritten where possible,
// and pages are checked one at a time inside a mixed word
// one transaction in the engine at a time, the next starts after the pop
// reset: a clearing pass writes every page used; two transactions queue meanwhile
// ---------------------------------------------------------------------------
module page_bitmap_allocator_top (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push,
	output logic               full,
	input  wire pba_pkg::in_t  in_data,
	output logic               empty,
	input  wire logic          pop,
	output pba_pkg::out_t      out_data
);
	logic          cmd_valid, cmd_take;
	pba_pkg::cmd_t cmd;

	pba_front u_front (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full), .in_data(in_data),
		.cmd_valid(cmd_valid), .cmd_take(cmd_take), .cmd(cmd)
	);

	pba_engine u_engine (
		.clk(clk), .arst_n(arst_n), .cmd_valid(cmd_valid), .cmd_take(cmd_take),
		.cmd(cmd), .empty(empty), .pop(pop), .out_data(out_data)
	);
endmodule
`default_nettype wire

@@ sim/page_bitmap_allocator_checker.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// page_bitmap_allocator_checker
// Watches both queue channels of the page allocator. Each accepted request
// updates a private bitmap, search hint and page counter. The response it
// implies is queued, and every popped response is compared field by field
// against the oldest queued one.
// ---------------------------------------------------------------------------
module page_bitmap_allocator_checker (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push,
	input  wire logic          full,
	input  wire pba_pkg::in_t  in_data,
	input  wire logic          empty,
	input  wire logic          pop,
	input  wire pba_pkg::out_t out_data,
	output int                 fail_count,
	output int                 pending,
	output int                 checked
);
	import pba_pkg::*;

	localparam int PAGES = NUM_PAGES;

	bit     used_map [0:PAGES-1];
	int     hint;
	int     alloc_total;
	out_t   expected_q[$];
	int     fails = 0;
	int     seen = 0;
	int     npend = 0;

	function automatic bit page_is_used(int p);
		if (p >= PAGES) begin
			return 1'b1;
		end
		return used_map[p];
	endfunction

	function automatic out_t apply_request(in_t req);
		out_t r;
		int   run;
		int   first;
		int   k;
		int   n;
		int   cleared;
		r = '0;
		r.ok = 1'b1;
		case (req.op)
			OP_ALLOC: begin
				n = req.count;
				r.ok = 1'b0;
				run = 0;
				if (n != 0 && n <= PAGES) begin
					for (int i = hint; i < PAGES; i++) begin
						if (used_map[i]) begin
							run = 0;
						end else begin
							run++;
							if (run == n) begin
								first = i + 1 - n;
								for (k = first; k <= i; k++) used_map[k] = 1'b1;
								alloc_total = (n >= PAGES - alloc_total) ? PAGES
									: alloc_total + n;
								k = i + 1;
								while (k < PAGES && used_map[k]) k++;
								hint = k;
								r.ok = 1'b1;
								r.start_page = first[15:0];
								break;
							end
						end
					end
				end
			end
			OP_FREE: begin
				if (req.page < PAGES) begin
					cleared = 0;
					for (k = 0; k < req.count && req.page + k < PAGES; k++) begin
						used_map[req.page + k] = 1'b0;
						cleared++;
					end
					alloc_total = (cleared >= alloc_total) ? 0 : alloc_total - cleared;
					hint = req.page;
					while (hint > 0 && !used_map[hint-1]) hint--;
				end
			end
			OP_MARK: begin
				if (req.page < PAGES) begin
					used_map[req.page] = req.value;
				end
			end
			default: begin
				r.page_used = page_is_used(req.page);
			end
		endcase
		r.pages_allocated = alloc_total[16:0];
		return r;
	endfunction

	assign fail_count = fails;
	assign checked    = seen;
	assign pending    = npend;

	always @(posedge clk or negedge arst_n) begin
		out_t want;
		int   errs;
		errs = 0;
		if (!arst_n) begin
			for (int i = 0; i < PAGES; i++) used_map[i] = 1'b1;
			hint = 0;
			alloc_total = 0;
			expected_q.delete();
		end else begin
			if (pop && !empty) begin
				if (expected_q.size() == 0) begin
					$error("response with no request outstanding");
					errs++;
				end else begin
					want = expected_q.pop_front();
					seen <= seen + 1;
					if (want.ok !== out_data.ok) begin
						$error("ok: expected %0d, got %0d", want.ok, out_data.ok);
						errs++;
					end
					if (want.start_page !== out_data.start_page) begin
						$error("start_page: expected %0d, got %0d",
							want.start_page, out_data.start_page);
						errs++;
					end
					if (want.page_used !== out_data.page_used) begin
						$error("page_used: expected %0d, got %0d",
							want.page_used, out_data.page_used);
						errs++;
					end
					if (want.pages_allocated !== out_data.pages_allocated) begin
						$error("pages_allocated: expected %0d, got %0d",
							want.pages_allocated, out_data.pages_allocated);
						errs++;
					end
				end
			end
			if (push && !full) begin
				expected_q.push_back(apply_request(in_data));
			end
		end
		fails <= fails + errs;
		npend <= expected_q.size();
	end
endmodule

@@ sim/page_bitmap_allocator_top_tb.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// page_bitmap_allocator_top_tb
// Drives allocate, free, mark and query transactions into the page allocator:
// a directed pass over the boundary cases, then random traffic kept mostly
// inside a low window of freed pages, with idle and stall phases on both
// sides. The checker reports the failure count.
// ---------------------------------------------------------------------------
module page_bitmap_allocator_top_tb;
	import pba_pkg::*;

	localparam int WINDOW      = 1024;
	localparam int RANDOM_REQS = 830;
	localparam int STALL_LIMIT = 1000000;

	logic  clk;
	logic  arst_n;
	logic  push;
	logic  full;
	in_t   in_data;
	logic  empty;
	logic  pop = 1'b0;
	out_t  out_data;
	int    fail_count;
	int    pending;
	int    checked;
	int    send_idle_pct;
	int    pop_stall_pct = 0;
	int    quiet_cycles = 0;

	page_bitmap_allocator_top dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.full     (full),
		.in_data  (in_data),
		.empty    (empty),
		.pop      (pop),
		.out_data (out_data)
	);

	page_bitmap_allocator_checker checker_i (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.in_data    (in_data),
		.empty      (empty),
		.pop        (pop),
		.out_data   (out_data),
		.fail_count (fail_count),
		.pending    (pending),
		.checked    (checked)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	always @(posedge clk) begin
		pop <= ($urandom_range(99) >= pop_stall_pct);
	end

	always @(posedge clk) begin
		if ((push && !full) || (pop && !empty)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("watchdog: no transaction for %0d cycles", STALL_LIMIT);
			$display("*** FAILED ***");
			$finish;
		end
	end

	task automatic issue(logic [1:0] op, int page, int count, bit value);
		in_t req;
		while ($urandom_range(99) < send_idle_pct) begin
			push <= 1'b0;
			@(posedge clk);
		end
		req.op = op;
		req.page = page[15:0];
		req.count = count[16:0];
		req.value = value;
		in_data <= req;
		push <= 1'b1;
		@(negedge clk);
		while (full) @(negedge clk);
		@(posedge clk);
	endtask

	task automatic random_request();
		int sel;
		sel = $urandom_range(99);
		if (sel < 8) begin
			case ($urandom_range(2))
				0: issue(OP_MARK, $urandom_range(65535), 0, $urandom_range(1));
				1: issue(OP_QUERY, $urandom_range(65535), 0, $urandom_range(1));
				default: issue(OP_FREE, $urandom_range(65535, 65000),
					$urandom_range(131071), $urandom_range(1));
			endcase
		end else if (sel < 43) begin
			issue(OP_ALLOC, $urandom_range(WINDOW-1),
				($urandom_range(9) == 0) ? $urandom_range(64, 1) : $urandom_range(8, 1),
				$urandom_range(1));
		end else if (sel < 71) begin
			issue(OP_FREE, $urandom_range(WINDOW-1), $urandom_range(32), $urandom_range(1));
		end else if (sel < 83) begin
			issue(OP_MARK, $urandom_range(WINDOW-1), $urandom_range(7), $urandom_range(1));
		end else begin
			issue(OP_QUERY, $urandom_range(WINDOW+15), $urandom_range(7), $urandom_range(1));
		end
	endtask

	initial begin
		arst_n <= 1'b0;
		push <= 1'b0;
		in_data <= '0;
		send_idle_pct = 0;
		pop_stall_pct = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: reset state, full-range runs, counter limits, past-end frees
		issue(OP_QUERY, 0, 0, 0);
		issue(OP_QUERY, 65535, 0, 0);
		issue(OP_ALLOC, 0, 0, 0);
		issue(OP_ALLOC, 0, 1, 0);
		issue(OP_FREE, 0, 65536, 0);
		issue(OP_ALLOC, 0, 65536, 1);
		issue(OP_MARK, 7, 0, 0);
		issue(OP_QUERY, 7, 0, 0);
		issue(OP_ALLOC, 0, 1, 0);
		issue(OP_FREE, 7, 0, 0);
		issue(OP_ALLOC, 0, 1, 0);
		issue(OP_FREE, 65530, 100, 1);
		issue(OP_MARK, 65535, 1, 1);
		issue(OP_FREE, 0, 65536, 0);
		issue(OP_FREE, 0, 10, 0);
		issue(OP_ALLOC, 0, 65536, 0);
		issue(OP_FREE, 0, WINDOW, 0);
		issue(OP_ALLOC, 0, 3, 0);
		issue(OP_ALLOC, 0, 5, 1);
		issue(OP_FREE, 1, 1, 0);
		issue(OP_ALLOC, 0, 1, 0);
		issue(OP_MARK, 2, 1, 1);
		issue(OP_QUERY, 2, 0, 1);

		for (int i = 0; i < RANDOM_REQS; i++) begin
			case (i * 5 / RANDOM_REQS)
				0: begin send_idle_pct = 0;  pop_stall_pct = 0;  end
				1: begin send_idle_pct = 70; pop_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  pop_stall_pct = 70; end
				3: begin send_idle_pct = 35; pop_stall_pct = 35; end
				default: begin send_idle_pct = 0; pop_stall_pct = 0; end
			endcase
			random_request();
		end
		push <= 1'b0;
		pop_stall_pct = 0;
		while (pending != 0) @(posedge clk);
		repeat (50) @(posedge clk);

		$display("covered: directed boundary cases plus %0d random transactions", RANDOM_REQS);
		$display("responses compared: %0d, failures: %0d", checked, fail_count);
		if (fail_count == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end
endmodule
